/* src/leaky_rate_network_euler_step_top_macros.svh */
// Assertion macros for the checker file of the rate network block.
`ifndef LEAKY_RATE_NETWORK_EULER_STEP_TOP_MACROS_SVH
`define LEAKY_RATE_NETWORK_EULER_STEP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LRN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/lrn_pkg.sv */
// Shared types, codes and helper functions of the rate network block.
package lrn_pkg;

  localparam int ACC_W = 60;

  localparam logic [2:0] CMD_WRITE_WEIGHT = 3'd0;
  localparam logic [2:0] CMD_WRITE_DRIVE  = 3'd1;
  localparam logic [2:0] CMD_SET_ACTIVITY = 3'd2;
  localparam logic [2:0] CMD_STEP         = 3'd3;
  localparam logic [2:0] CMD_DRIVEN_STEP  = 3'd4;

  localparam logic [1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [1:0] REG_LEAK_RATE      = 2'd1;
  localparam logic [1:0] REG_DRIVE_STRENGTH = 2'd2;
  localparam logic [1:0] REG_ACTIVE_NEURONS = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         row_index;
    logic [4:0]         column_index;
    logic signed [31:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [4:0]         neuron_index;
    logic [15:0]        rate;
    logic signed [31:0] activity;
    logic               last;
  } res_item_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_P,
    ACC_ADD_P,
    ACC_SUB_P,
    ACC_LOAD_X
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  // Floor of x / 2^16, saturated to 32 bits signed.
  function automatic logic signed [31:0] sat_shift16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-17:0] s;
    s = x[ACC_W-1:16];
    if (s > (ACC_W-16)'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (s < -(ACC_W-16)'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Unsigned quotient by shift and subtract, used at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table entry K of Entries, evaluated at elaboration only.
  function automatic logic [15:0] sig_value(input int K, input int Entries);
    longint x;
    longint t;
    longint acc;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] low;
    logic [63:0] hi;
    x = longint'(udiv64(64'(K) << 20, 64'(Entries))) - 64'sd524288;
    if (x == 0) begin
      return 16'd32768;
    end
    t = (x < 0) ? -x : x;
    y = 64'(t) << 12;
    term = 64'h1_0000_0000;
    acc = 64'sh1_0000_0000;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * y) >> 32, 64'(n));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > 64'sh0_ffff_ffff) begin
      acc = 64'sh0_ffff_ffff;
    end
    r = 64'(acc);
    for (int n = 0; n < 4; n++) begin
      r = (r * r + 64'd2147483648) >> 32;
    end
    den = 64'h1_0000_0000 + r;
    low = udiv64(r * 64'd65536 + (den >> 1), den);
    if (x < 0) begin
      return (low > 64'd65535) ? 16'hffff : low[15:0];
    end
    hi = (low > 64'd65536) ? 64'd0 : 64'd65536 - low;
    return (hi > 64'd65535) ? 16'hffff : hi[15:0];
  endfunction

endpackage

/* src/lrn_mac.sv */
// Shared multiplier with product register and accumulator.
module lrn_mac (
  input  logic                              clk,
  input  lrn_pkg::mac_ctrl_t                ctrl,
  input  logic signed [33:0]                op_a,
  input  logic signed [25:0]                op_b,
  input  logic signed [lrn_pkg::ACC_W-1:0]  x_in,
  output logic signed [lrn_pkg::ACC_W-1:0]  prod,
  output logic signed [lrn_pkg::ACC_W-1:0]  acc
);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
    case (ctrl.acc_op)
      lrn_pkg::ACC_LOAD_P: acc <= prod;
      lrn_pkg::ACC_ADD_P:  acc <= acc + prod;
      lrn_pkg::ACC_SUB_P:  acc <= acc - prod;
      lrn_pkg::ACC_LOAD_X: acc <= x_in;
      default:             acc <= acc;
    endcase
  end

endmodule

/* src/lrn_sig_rom.sv */
// Sigmoid lookup table with registered read.
module lrn_sig_rom #(
  parameter int ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  output logic [15:0]                data
);

  logic [15:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam logic [15:0] V = lrn_pkg::sig_value(k, ENTRIES);
    assign rom[k] = V;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

/* src/leaky_rate_network_euler_step_top.sv */
// Write commands leave cmd_stall low; set activity keeps it high until its new rate is written.
// A step first forms the weighted sums for n active neurons on the one shared
// multiply-accumulate unit, one weight product per cycle, then updates each neuron in turn.
// Results leave through an output register; a stalled result holds the update sequencer.
// After reset a clearing pass zeroes the weight, activity and drive stores and sets each rate
// to one half; cmd_stall is high meanwhile, and configuration writes are taken as usual.
module leaky_rate_network_euler_step_top #(
  parameter int NEURONS = 32,
  parameter int SIGMOID_TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lrn_pkg::cmd_item_t cmd_word,
  output logic               res_valid,
  input  logic               res_stall,
  output lrn_pkg::res_item_t res_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(NEURONS);
  localparam int CW = IW + 1;
  localparam int WA = $clog2(NEURONS * NEURONS);
  localparam int EW = $clog2(SIGMOID_TABLE_ENTRIES);
  localparam int AW = lrn_pkg::ACC_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SUM, S_DRAIN,
    U_RD, U_LD, U_LK, U_DR, U_D16, U_TS, U_AD, U_NA,
    G_MUL, G_IDX, G_WR
  } state_t;

  state_t state;

  logic [23:0] time_step;
  logic [23:0] leak_rate;
  logic [23:0] drive_strength;
  logic [5:0]  active_neurons;

  logic [WA-1:0] clr_cnt;
  logic [CW-1:0] n_r;
  logic          driven;
  logic          setact;
  logic [IW-1:0] si;
  logic [IW-1:0] sj;
  logic [WA-1:0] base;
  logic          v1, v2, v3;
  logic          first1, first2;
  logic          last1, last2, last3;
  logic [IW-1:0] row1, row2, row3;
  logic signed [31:0] a_r, drv_r, d16_r, na_r;
  logic          sig_lo, sig_hi;

  // Memory ports
  logic          w_we;
  logic [WA-1:0] w_wa, w_ra;
  logic signed [31:0] w_wd, w_rd;
  logic          act_we, drv_we, rate_we, sum_we;
  logic [IW-1:0] act_wa, drv_wa, rate_wa;
  logic signed [31:0] act_wd, drv_wd;
  logic [15:0]   rate_wd, rate_rd;
  logic signed [31:0] act_rd, drv_rd, sum_rd;

  logic signed [31:0] w_mem   [NEURONS*NEURONS];
  logic signed [31:0] act_mem [NEURONS];
  logic signed [31:0] drv_mem [NEURONS];
  logic [15:0]        rate_mem[NEURONS];
  logic signed [31:0] sum_mem [NEURONS];

  lrn_pkg::mac_ctrl_t   mctrl;
  logic signed [33:0]   op_a;
  logic signed [25:0]   op_b;
  logic signed [AW-1:0] x_in, prod, acc;
  logic [EW-1:0]        rom_addr;
  logic [15:0]          rom_data;

  logic          accept, row_ok, col_ok, out_free, clr_small, n_zero;
  logic [CW-1:0] n_eff;
  logic signed [32:0] sig_s;
  logic signed [31:0] acc_sat;

  assign pready    = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign row_ok    = 32'(cmd_word.row_index) < NEURONS;
  assign col_ok    = 32'(cmd_word.column_index) < NEURONS;
  assign out_free  = !res_valid || !res_stall;
  assign clr_small = 32'(clr_cnt) < NEURONS;
  assign n_eff     = (32'(active_neurons) > NEURONS) ? CW'(NEURONS) : CW'(active_neurons);
  assign n_zero    = (active_neurons == 6'd0);
  assign sig_s     = 33'(na_r) + 33'sd524288;
  assign acc_sat   = lrn_pkg::sat_shift16(acc);

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      lrn_pkg::REG_TIME_STEP:      prdata = {8'd0, time_step};
      lrn_pkg::REG_LEAK_RATE:      prdata = {8'd0, leak_rate};
      lrn_pkg::REG_DRIVE_STRENGTH: prdata = {8'd0, drive_strength};
      lrn_pkg::REG_ACTIVE_NEURONS: prdata = {26'd0, active_neurons};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= 24'd655;
      leak_rate      <= 24'd65536;
      drive_strength <= 24'd0;
      active_neurons <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        lrn_pkg::REG_TIME_STEP:      time_step      <= pwdata[23:0];
        lrn_pkg::REG_LEAK_RATE:      leak_rate      <= pwdata[23:0];
        lrn_pkg::REG_DRIVE_STRENGTH: drive_strength <= pwdata[23:0];
        lrn_pkg::REG_ACTIVE_NEURONS: active_neurons <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Memory write and read selection.
  always_comb begin
    w_we    = 1'b0;
    w_wa    = clr_cnt;
    w_wd    = 32'sd0;
    act_we  = 1'b0;
    act_wa  = IW'(clr_cnt);
    act_wd  = 32'sd0;
    drv_we  = 1'b0;
    drv_wa  = IW'(clr_cnt);
    drv_wd  = 32'sd0;
    rate_we = 1'b0;
    rate_wa = IW'(clr_cnt);
    rate_wd = 16'd32768;
    if (state == S_CLEAR) begin
      w_we    = 1'b1;
      act_we  = clr_small;
      drv_we  = clr_small;
      rate_we = clr_small;
    end else if (accept) begin
      w_wa   = WA'(32'(cmd_word.row_index) * NEURONS + 32'(cmd_word.column_index));
      w_wd   = cmd_word.value;
      w_we   = (cmd_word.command == lrn_pkg::CMD_WRITE_WEIGHT) && row_ok && col_ok;
      act_wa = IW'(cmd_word.row_index);
      act_wd = cmd_word.value;
      act_we = (cmd_word.command == lrn_pkg::CMD_SET_ACTIVITY) && row_ok;
      drv_wa = IW'(cmd_word.row_index);
      drv_wd = cmd_word.value;
      drv_we = (cmd_word.command == lrn_pkg::CMD_WRITE_DRIVE) && row_ok;
    end else if (state == G_WR) begin
      rate_wa = si;
      rate_wd = rom_data;
      rate_we = setact || out_free;
      act_wa  = si;
      act_wd  = na_r;
      act_we  = !setact && out_free;
    end
  end

  assign w_ra   = base + WA'(sj);
  assign sum_we = v3 && last3;

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    w_rd <= w_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    act_rd <= act_mem[si];
  end

  always_ff @(posedge clk) begin
    if (drv_we) begin
      drv_mem[drv_wa] <= drv_wd;
    end
    drv_rd <= drv_mem[si];
  end

  always_ff @(posedge clk) begin
    if (rate_we) begin
      rate_mem[rate_wa] <= rate_wd;
    end
    rate_rd <= rate_mem[sj];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[row3] <= acc_sat;
    end
    sum_rd <= sum_mem[si];
  end

  // Operand selection for the shared unit.
  always_comb begin
    mctrl.mul_en = 1'b0;
    mctrl.acc_op = lrn_pkg::ACC_HOLD;
    op_a = 34'(w_rd);
    op_b = $signed({10'd0, rate_rd});
    x_in = $signed({{(AW-48){a_r[31]}}, a_r, 16'd0});
    rom_addr = prod[20+EW-1:20];
    unique case (state)
      S_SUM, S_DRAIN: begin
        mctrl.mul_en = v1;
        if (v2) begin
          mctrl.acc_op = first2 ? lrn_pkg::ACC_LOAD_P : lrn_pkg::ACC_ADD_P;
        end
      end
      U_LD: begin
        mctrl.mul_en = 1'b1;
        mctrl.acc_op = lrn_pkg::ACC_LOAD_X;
        op_a = 34'(act_rd);
        op_b = $signed({2'd0, leak_rate});
        x_in = $signed({{(AW-48){sum_rd[31]}}, sum_rd, 16'd0});
      end
      U_LK: begin
        mctrl.mul_en = 1'b1;
        mctrl.acc_op = lrn_pkg::ACC_SUB_P;
        op_a = 34'(drv_r) - 34'(a_r);
        op_b = $signed({2'd0, drive_strength});
      end
      U_DR: begin
        mctrl.acc_op = driven ? lrn_pkg::ACC_ADD_P : lrn_pkg::ACC_HOLD;
      end
      U_TS: begin
        mctrl.mul_en = 1'b1;
        mctrl.acc_op = lrn_pkg::ACC_LOAD_X;
        op_a = 34'(d16_r);
        op_b = $signed({2'd0, time_step});
      end
      U_AD: begin
        mctrl.acc_op = lrn_pkg::ACC_ADD_P;
      end
      G_MUL: begin
        mctrl.mul_en = 1'b1;
        op_a = $signed({14'd0, sig_s[19:0]});
        op_b = 26'(SIGMOID_TABLE_ENTRIES);
      end
      // The clamped address is held while a result waits so the table word stays valid.
      G_IDX, G_WR: begin
        if (sig_lo) begin
          rom_addr = '0;
        end else if (sig_hi) begin
          rom_addr = EW'(SIGMOID_TABLE_ENTRIES - 1);
        end
      end
      default: ;
    endcase
  end

  lrn_mac u_mac (
    .clk  (clk),
    .ctrl (mctrl),
    .op_a (op_a),
    .op_b (op_b),
    .x_in (x_in),
    .prod (prod),
    .acc  (acc)
  );

  lrn_sig_rom #(
    .ENTRIES (SIGMOID_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
      si        <= '0;
      sj        <= '0;
      base      <= '0;
      n_r       <= '0;
      driven    <= 1'b0;
      setact    <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !(state == G_WR && !setact)) begin
        res_valid <= 1'b0;
      end
      // Weight product pipeline: read, multiply, accumulate, write back.
      v1     <= (state == S_SUM);
      first1 <= (sj == '0);
      last1  <= (CW'(sj) == n_r - CW'(1));
      row1   <= si;
      v2     <= v1;
      first2 <= first1;
      last2  <= last1;
      row2   <= row1;
      v3     <= v2;
      last3  <= last2;
      row3   <= row2;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + WA'(1);
          if (clr_cnt == WA'(NEURONS * NEURONS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_word.command)
              lrn_pkg::CMD_SET_ACTIVITY: begin
                if (row_ok) begin
                  setact <= 1'b1;
                  si     <= IW'(cmd_word.row_index);
                  na_r   <= cmd_word.value;
                  state  <= G_MUL;
                end
              end
              lrn_pkg::CMD_STEP, lrn_pkg::CMD_DRIVEN_STEP: begin
                if (!n_zero) begin
                  setact <= 1'b0;
                  driven <= (cmd_word.command == lrn_pkg::CMD_DRIVEN_STEP);
                  n_r    <= n_eff;
                  si     <= '0;
                  sj     <= '0;
                  base   <= '0;
                  state  <= S_SUM;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          if (CW'(sj) == n_r - CW'(1)) begin
            sj   <= '0;
            base <= base + WA'(NEURONS);
            if (CW'(si) == n_r - CW'(1)) begin
              state <= S_DRAIN;
            end else begin
              si <= si + IW'(1);
            end
          end else begin
            sj <= sj + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            si    <= '0;
            state <= U_RD;
          end
        end
        U_RD: state <= U_LD;
        U_LD: begin
          a_r   <= act_rd;
          drv_r <= drv_rd;
          state <= U_LK;
        end
        U_LK:  state <= U_DR;
        U_DR:  state <= U_D16;
        U_D16: begin
          d16_r <= acc_sat;
          state <= U_TS;
        end
        U_TS: state <= U_AD;
        U_AD: state <= U_NA;
        U_NA: begin
          na_r  <= acc_sat;
          state <= G_MUL;
        end
        G_MUL: begin
          sig_lo <= sig_s < 0;
          sig_hi <= sig_s >= 33'sd1048576;
          state  <= G_IDX;
        end
        G_IDX: state <= G_WR;
        G_WR: begin
          if (setact) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res_valid             <= 1'b1;
            res_word.neuron_index <= 5'(si);
            res_word.rate         <= rom_data;
            res_word.activity     <= na_r;
            res_word.last         <= (CW'(si) == n_r - CW'(1));
            if (CW'(si) == n_r - CW'(1)) begin
              state <= S_IDLE;
            end else begin
              si    <= si + IW'(1);
              state <= U_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/lrn_check.sv */
// Port-level checker for the rate network block, bound to its top level.
`include "leaky_rate_network_euler_step_top_macros.svh"

module lrn_check (
  input logic               clk,
  input logic               rst,
  input logic               cmd_stall,
  input logic               res_valid,
  input logic               res_stall,
  input lrn_pkg::res_item_t res_word
);

  // A stalled result word stays put.
  `LRN_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

  // The clearing pass keeps commands out right after reset.
  `LRN_ASSERT_IMP(a_clear_stall, $past(rst), cmd_stall)

  // Results only appear while a step is running.
  `LRN_ASSERT_IMP(a_res_in_step, $rose(res_valid), $past(cmd_stall))

  // Once the last result of a step is taken, nothing follows at once.
  `LRN_ASSERT_NXT(a_last_ends, res_valid && !res_stall && res_word.last, !res_valid)

endmodule

bind leaky_rate_network_euler_step_top lrn_check u_check (.*);

/* tb/tb_top.sv */
// Self-checking testbench of the leaky rate network Euler step block.
`timescale 1ns / 100ps

module tb_top;

  localparam int NEUR = 32;
  localparam int SIG_N = 1024;
  localparam int HALF = 524288;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  lrn_pkg::cmd_item_t cmd_word;
  logic res_valid;
  logic res_stall;
  lrn_pkg::res_item_t res_word;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  leaky_rate_network_euler_step_top DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the network state and of the registers.
  logic signed [31:0] weight_m [NEUR][NEUR];
  logic signed [31:0] activity_m [NEUR];
  logic [15:0] rate_m [NEUR];
  logic signed [31:0] drive_m [NEUR];
  logic [15:0] sig_tab [SIG_N];
  logic [23:0] time_step_m;
  logic [23:0] leak_m;
  logic [23:0] drive_gain_m;
  logic [5:0] active_m;

  lrn_pkg::res_item_t neuron_q[$];
  int mismatches;
  int idle_cycles;
  bit calm;

  typedef struct {
    lrn_pkg::cmd_item_t w;
    bit typed;
    logic [15:0] t_rate;
    logic signed [31:0] t_act;
  } drow_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sigmoid table entry k; exp(-t) in Q0.32 by a Taylor series of exp(-t/16) squared four times.
  function automatic logic [15:0] sig_entry(input int k);
    longint x;
    longint sum;
    logic [63:0] y;
    logic [63:0] part;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] lo;
    x = (longint'(k) * 1048576) / SIG_N - HALF;
    if (x == 0) begin
      return 16'd32768;
    end
    y = 64'(x < 0 ? -x : x) << 12;
    part = 64'h1_0000_0000;
    sum = 64'sh1_0000_0000;
    for (int n = 1; n <= 12; n++) begin
      part = ((part * y) >> 32) / 64'(n);
      sum = (n % 2 == 1) ? sum - longint'(part) : sum + longint'(part);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sh0_ffff_ffff) sum = 64'sh0_ffff_ffff;
    e = 64'(sum);
    for (int n = 0; n < 4; n++) begin
      e = (e * e + 64'd2147483648) >> 32;
    end
    den = 64'h1_0000_0000 + e;
    lo = (e * 64'd65536 + (den >> 1)) / den;
    if (x < 0) begin
      return (lo > 65535) ? 16'hffff : lo[15:0];
    end
    lo = (lo > 65536) ? 64'd0 : 64'd65536 - lo;
    return (lo > 65535) ? 16'hffff : lo[15:0];
  endfunction

  function automatic logic [15:0] rate_of(input logic signed [31:0] a);
    longint s;
    s = longint'(a) + HALF;
    if (s < 0) return sig_tab[0];
    if (s >= 2 * HALF) return sig_tab[SIG_N-1];
    return sig_tab[(s * SIG_N) >>> 20];
  endfunction

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Applies one accepted word to the mirror and queues the neuron reports it causes.
  function automatic void network_update(input lrn_pkg::cmd_item_t w, input bit typed,
                                         input logic [15:0] t_rate,
                                         input logic signed [31:0] t_act);
    int n;
    longint acc;
    longint d;
    logic signed [31:0] sums [NEUR];
    logic signed [31:0] d16;
    lrn_pkg::res_item_t r;
    case (w.command)
      lrn_pkg::CMD_WRITE_WEIGHT: weight_m[w.row_index][w.column_index] = w.value;
      lrn_pkg::CMD_WRITE_DRIVE: drive_m[w.row_index] = w.value;
      lrn_pkg::CMD_SET_ACTIVITY: begin
        activity_m[w.row_index] = w.value;
        rate_m[w.row_index] = rate_of(w.value);
      end
      lrn_pkg::CMD_STEP, lrn_pkg::CMD_DRIVEN_STEP: begin
        n = (active_m > NEUR) ? NEUR : active_m;
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int j = 0; j < n; j++) begin
            acc += longint'(weight_m[i][j]) * longint'({1'b0, rate_m[j]});
          end
          sums[i] = clip32(acc >>> 16);
        end
        for (int i = 0; i < n; i++) begin
          d = longint'(sums[i]) * 65536 - longint'({1'b0, leak_m}) * longint'(activity_m[i]);
          if (w.command == lrn_pkg::CMD_DRIVEN_STEP) begin
            d += longint'({1'b0, drive_gain_m})
                 * (longint'(drive_m[i]) - longint'(activity_m[i]));
          end
          d16 = clip32(d >>> 16);
          activity_m[i] = clip32(longint'(activity_m[i])
                          + ((longint'({1'b0, time_step_m}) * longint'(d16)) >>> 16));
          rate_m[i] = rate_of(activity_m[i]);
          r.neuron_index = i[4:0];
          r.rate = typed ? t_rate : rate_m[i];
          r.activity = typed ? t_act : activity_m[i];
          r.last = (i == n - 1);
          neuron_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input lrn_pkg::cmd_item_t w, input bit typed = 1'b0,
                           input logic [15:0] t_rate = '0,
                           input logic signed [31:0] t_act = '0);
    if (!calm && $urandom_range(0, 99) < 6) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    network_update(w, typed, t_rate, t_act);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lrn_pkg::REG_TIME_STEP: time_step_m = data[23:0];
      lrn_pkg::REG_LEAK_RATE: leak_m = data[23:0];
      lrn_pkg::REG_DRIVE_STRENGTH: drive_gain_m = data[23:0];
      default: active_m = data[5:0];
    endcase
  endtask

  // Registers change only once the block has drained.
  task automatic set_config(input logic [23:0] ts, input logic [23:0] lk,
                            input logic [23:0] dg, input logic [5:0] an);
    cmd_valid <= 1'b0;
    while (neuron_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    reg_write(lrn_pkg::REG_TIME_STEP, {8'($urandom), ts});
    reg_write(lrn_pkg::REG_LEAK_RATE, {8'($urandom), lk});
    reg_write(lrn_pkg::REG_DRIVE_STRENGTH, {8'($urandom), dg});
    reg_write(lrn_pkg::REG_ACTIVE_NEURONS, {26'($urandom), an});
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 2 * HALF)) - HALF;
      default: return $signed($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= !calm && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    lrn_pkg::res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (neuron_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", res_word);
      end else begin
        want = neuron_q.pop_front();
        if (res_word.neuron_index !== want.neuron_index || res_word.rate !== want.rate
            || res_word.activity !== want.activity || res_word.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p, got %p", want, res_word);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    drow_t dir [$];
    drow_t d;
    lrn_pkg::cmd_item_t w;
    int n;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;
    for (int k = 0; k < SIG_N; k++) sig_tab[k] = sig_entry(k);
    for (int i = 0; i < NEUR; i++) begin
      for (int j = 0; j < NEUR; j++) weight_m[i][j] = '0;
      activity_m[i] = '0;
      rate_m[i] = 16'd32768;
      drive_m[i] = '0;
    end
    time_step_m = 24'd655;
    leak_m = 24'd65536;
    drive_gain_m = '0;
    active_m = 6'd32;

    // A fresh network stays at rest: activity zero, rate one half.
    dir.push_back('{'{lrn_pkg::CMD_STEP, 5'd0, 5'd0, 32'sd0}, 1'b1, 16'd32768, 32'sd0});
    dir.push_back('{'{lrn_pkg::CMD_WRITE_WEIGHT, 5'd0, 5'd1, 32'sh7fffffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_WRITE_WEIGHT, 5'd1, 5'd0, 32'sh80000000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_WRITE_WEIGHT, 5'd31, 5'd31, 32'sh00010000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_WRITE_DRIVE, 5'd0, 5'd31, 32'sh7fffffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_WRITE_DRIVE, 5'd31, 5'd0, 32'sh80000000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd0, 5'd0, 32'sh7fffffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd1, 5'd0, 32'sh80000000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd2, 5'd0, 32'sh00080000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd3, 5'd0, 32'shfff80000}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd4, 5'd0, 32'sh0007ffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd5, 5'd0, 32'shfff7ffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_SET_ACTIVITY, 5'd31, 5'd31, 32'sd0}, 1'b0, '0, '0});
    dir.push_back('{'{CMD_SPARE_LO, 5'd31, 5'd31, 32'shffffffff}, 1'b0, '0, '0});
    dir.push_back('{'{CMD_SPARE_MID, 5'd1, 5'd1, 32'sd1}, 1'b0, '0, '0});
    dir.push_back('{'{CMD_SPARE_HI, 5'd0, 5'd0, 32'sd0}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_STEP, 5'd31, 5'd31, 32'shffffffff}, 1'b0, '0, '0});
    dir.push_back('{'{lrn_pkg::CMD_DRIVEN_STEP, 5'd0, 5'd0, 32'sd0}, 1'b0, '0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir[k]) begin
      d = dir[k];
      send_word(d.w, d.typed, d.t_rate, d.t_act);
    end

    // Extremes first, then a long stretch with no idling, then ordinary settings.
    // One pass asks for more neurons than exist and one for none at all.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(24'hffffff, 24'hffffff, 24'hffffff, 6'd1);
        1: set_config(24'd0, 24'd0, 24'd0, 6'd32);
        2: set_config(24'd6553, 24'd0, 24'hffffff, 6'd3);
        4: set_config(24'($urandom_range(0, 32768)), 24'($urandom_range(0, 131072)),
                      24'($urandom_range(0, 65536)), 6'd40);
        5: set_config(24'($urandom_range(0, 32768)), 24'($urandom_range(0, 131072)),
                      24'($urandom_range(0, 65536)), 6'd32);
        6: set_config(24'($urandom_range(0, 65536)), 24'($urandom_range(0, 131072)),
                      24'($urandom_range(0, 131072)), 6'd0);
        default: set_config(24'($urandom_range(0, 65536)), 24'($urandom_range(0, 131072)),
                            24'($urandom_range(0, 131072)), 6'($urandom_range(2, 8)));
      endcase
      calm = (p == 3);
      n = (active_m > NEUR) ? NEUR : active_m;
      if (n == 0) n = NEUR;
      for (int k = 0; k < 45; k++) begin
        w.value = pick_value();
        w.column_index = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
        w.row_index = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: w.command = lrn_pkg::CMD_WRITE_WEIGHT;
          7, 8: w.command = lrn_pkg::CMD_WRITE_DRIVE;
          9, 10, 11: w.command = lrn_pkg::CMD_SET_ACTIVITY;
          12, 13, 14: w.command = lrn_pkg::CMD_STEP;
          15, 16, 17: w.command = lrn_pkg::CMD_DRIVEN_STEP;
          default: w.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        endcase
        send_word(w);
      end
    end
    cmd_valid <= 1'b0;
    calm = 1'b0;
    while (neuron_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lrn_pkg.sv
src/lrn_mac.sv
src/lrn_sig_rom.sv
src/leaky_rate_network_euler_step_top.sv
src/lrn_check.sv
tb/tb_top.sv
